// File: design/gbcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcw_pkg
// Shared types, constants and register codes for the grid box cell walker.
// ----------------------------------------------------------------------------
package gbcw_pkg;

  localparam int MAX_AXES_DEF       = 3;
  localparam int MAX_LEVEL_BITS_DEF = 8;
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int IDX_W              = 24;
  localparam int LVL_W              = 4;
  localparam int AXC_W              = 2;
  localparam int CFG_AW             = 5;

  localparam logic [2:0] REG_AXIS_COUNT = 3'd0;
  localparam logic [2:0] REG_LEVEL_BITS = 3'd1;
  localparam logic [2:0] REG_MIN_X      = 3'd2;
  localparam logic [2:0] REG_MAX_X      = 3'd3;
  localparam logic [2:0] REG_MIN_Y      = 3'd4;
  localparam logic [2:0] REG_MAX_Y      = 3'd5;
  localparam logic [2:0] REG_MIN_Z      = 3'd6;
  localparam logic [2:0] REG_MAX_Z      = 3'd7;

  localparam logic KIND_BOX  = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic                              kind;
    logic signed [COORD_WIDTH_DEF-1:0] box_min_x;
    logic signed [COORD_WIDTH_DEF-1:0] box_max_x;
    logic signed [COORD_WIDTH_DEF-1:0] box_min_y;
    logic signed [COORD_WIDTH_DEF-1:0] box_max_y;
    logic signed [COORD_WIDTH_DEF-1:0] box_min_z;
    logic signed [COORD_WIDTH_DEF-1:0] box_max_z;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] leaf_index;
    logic             is_last;
    logic             idle_step;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } lane_ctl_t;

endpackage

// File: design/gbcw_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcw_lane
// One axis: cell size, then a restoring divider that quantizes the box's low
// and high bounds together, one quotient bit per cycle, with clamping.
// ----------------------------------------------------------------------------
module gbcw_lane import gbcw_pkg::*; #(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int MAX_LEVEL_BITS = MAX_LEVEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [LVL_W-1:0]              lvl,
  input  logic signed [COORD_WIDTH-1:0] wmin,
  input  logic signed [COORD_WIDTH-1:0] wmax,
  input  logic signed [COORD_WIDTH-1:0] bmin,
  input  logic signed [COORD_WIDTH-1:0] bmax,
  output logic                          done,
  output logic [MAX_LEVEL_BITS-1:0]     lo_cell,
  output logic [MAX_LEVEL_BITS-1:0]     hi_cell
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int CW  = $clog2(DW + 1);

  logic [DW-1:0]           dvs_r;
  logic [DW-1:0]           qa_r, qb_r, ra_r, rb_r;
  logic                    nega_r, negb_r;
  logic [CW-1:0]           cnt_r;
  logic                    busy_r, done_r;
  logic [MAX_LEVEL_BITS-1:0] top;
  logic [DW-1:0]           span, size, offa, offb, tra, trb;
  logic [DW-1:0]           qa_c, qb_c;
  logic [MAX_LEVEL_BITS-1:0] la, lb;

  always_comb begin
    span = DW'($signed({wmax[COORD_WIDTH-1], wmax}) - $signed({wmin[COORD_WIDTH-1], wmin}));
    size = span >> lvl;
    if (!(wmin < wmax) || size == '0) begin
      size = DW'(1);
    end
    offa = DW'($signed({bmin[COORD_WIDTH-1], bmin}) - $signed({wmin[COORD_WIDTH-1], wmin}));
    offb = DW'($signed({bmax[COORD_WIDTH-1], bmax}) - $signed({wmin[COORD_WIDTH-1], wmin}));
    tra  = {ra_r[DW-2:0], qa_r[DW-1]};
    trb  = {rb_r[DW-2:0], qb_r[DW-1]};
    top  = MAX_LEVEL_BITS'((32'd1 << lvl) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        dvs_r  <= size;
        qa_r   <= offa;
        qb_r   <= offb;
        ra_r   <= '0;
        rb_r   <= '0;
        nega_r <= bmin < wmin;
        negb_r <= bmax < wmin;
      end else if (busy_r) begin
        if (tra >= dvs_r) begin
          ra_r <= tra - dvs_r;
          qa_r <= {qa_r[DW-2:0], 1'b1};
        end else begin
          ra_r <= tra;
          qa_r <= {qa_r[DW-2:0], 1'b0};
        end
        if (trb >= dvs_r) begin
          rb_r <= trb - dvs_r;
          qb_r <= {qb_r[DW-2:0], 1'b1};
        end else begin
          rb_r <= trb;
          qb_r <= {qb_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    qa_c = qa_r;
    qb_c = qb_r;
    if (nega_r) la = '0;
    else if (qa_c > DW'(top)) la = top;
    else la = qa_c[MAX_LEVEL_BITS-1:0];
    if (negb_r) lb = '0;
    else if (qb_c > DW'(top)) lb = top;
    else lb = qb_c[MAX_LEVEL_BITS-1:0];
  end

  assign done    = done_r;
  assign lo_cell = la;
  assign hi_cell = (lb < la) ? la : lb;

endmodule

// File: design/gbcw_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcw_walker
// Merging stage: holds the per-axis ranges, runs the odometer and forms the
// linear index of the current cell.
// ----------------------------------------------------------------------------
module gbcw_walker import gbcw_pkg::*; #(
  parameter int MAX_AXES       = MAX_AXES_DEF,
  parameter int MAX_LEVEL_BITS = MAX_LEVEL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  logic                                   step,
  input  logic [MAX_AXES-1:0][MAX_LEVEL_BITS-1:0] lo_in,
  input  logic [MAX_AXES-1:0][MAX_LEVEL_BITS-1:0] hi_in,
  input  logic [AXC_W:0]                         naxes,
  input  logic [LVL_W-1:0]                       lvl,
  output logic                                   active,
  output out_word_t                              res
);

  logic [MAX_AXES-1:0][MAX_LEVEL_BITS-1:0] lo_r, hi_r, cur_r, lo_nxt, hi_nxt, cur_nxt;
  logic                                    act_r, act_nxt, carry, last;
  logic [IDX_W-1:0]                        idx;
  logic [MAX_LEVEL_BITS-1:0]               cmask;

  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    cur_nxt = cur_r;
    act_nxt = act_r;
    carry   = 1'b1;
    if (load) begin
      for (int a = 0; a < MAX_AXES; a++) begin
        if (a < 32'(naxes)) begin
          lo_nxt[a]  = lo_in[a];
          hi_nxt[a]  = hi_in[a];
          cur_nxt[a] = lo_in[a];
        end else begin
          lo_nxt[a]  = '0;
          hi_nxt[a]  = '0;
          cur_nxt[a] = '0;
        end
      end
    end else if (step) begin
      for (int a = 0; a < MAX_AXES; a++) begin
        if (carry && a < 32'(naxes)) begin
          if (cur_r[a] < hi_r[a]) begin
            cur_nxt[a] = cur_r[a] + MAX_LEVEL_BITS'(1);
            carry      = 1'b0;
          end else begin
            cur_nxt[a] = lo_r[a];
          end
        end
      end
    end
    last = 1'b1;
    for (int a = 0; a < MAX_AXES; a++) begin
      if (a < 32'(naxes) && cur_nxt[a] != hi_nxt[a]) last = 1'b0;
    end
    cmask = MAX_LEVEL_BITS'((32'd1 << lvl) - 32'd1);
    idx   = '0;
    for (int a = 0; a < MAX_AXES; a++) begin
      if (a < 32'(naxes)) begin
        idx = (idx << lvl) | IDX_W'(cur_nxt[a] & cmask);
      end
    end
    if (load) act_nxt = !last;
    else if (step && last) act_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r  <= '0;
      hi_r  <= '0;
      cur_r <= '0;
      act_r <= 1'b0;
    end else begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      cur_r <= cur_nxt;
      act_r <= act_nxt;
    end
  end

  assign active         = act_r;
  assign res.leaf_index = idx;
  assign res.is_last    = last;
  assign res.idle_step  = 1'b0;

endmodule

// File: design/grid_box_cell_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_box_cell_walker
// Bins an axis-aligned box onto a uniform grid and walks its cells.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall; each gives exactly one output word
// on out_valid/out_stall. A box word starts one divider lane per axis; the
// lanes quantize both box bounds in parallel, one quotient bit per cycle, and
// the input stalls until they are done and the box's output word is formed.
// A step word is served by the odometer and its output word is registered
// from it, so step words flow at one per cycle when the receiver never stalls.
// Configuration goes through the APB port; write it only while idle.
// After reset the registers hold their defaults and no walk is active; a step
// then reports idle. While out_stall is high the output word holds and at
// most one more input word is accepted and worked.
// ----------------------------------------------------------------------------
module grid_box_cell_walker import gbcw_pkg::*; #(
  parameter int MAX_AXES       = MAX_AXES_DEF,
  parameter int MAX_LEVEL_BITS = MAX_LEVEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int COORD_WIDTH = COORD_WIDTH_DEF;
  localparam int NL = (MAX_AXES < 3) ? MAX_AXES : 3;

  logic [AXC_W-1:0]        axc_r;
  logic [LVL_W-1:0]        lvl_r;
  logic signed [31:0]      wmin_r [3];
  logic signed [31:0]      wmax_r [3];
  logic [AXC_W:0]          naxes;
  logic [LVL_W-1:0]        lvl;
  logic                    cfg_wr;
  logic [2:0]              reg_sel;

  logic                    busy_r, pend_r, ov_r;
  out_word_t               od_r, pend_d_r;
  logic                    accept, lanes_go, lanes_done;
  logic                    do_step, do_load;
  logic                    in_act;
  out_word_t               wres, new_res;
  logic                    new_valid;
  logic [MAX_AXES-1:0][MAX_LEVEL_BITS-1:0] lo_c, hi_c;
  logic [NL-1:0]           ldone;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axc_r <= AXC_W'(3);
      lvl_r <= LVL_W'(4);
      for (int a = 0; a < 3; a++) begin
        wmin_r[a] <= '0;
        wmax_r[a] <= 32'sd1024;
      end
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_AXIS_COUNT: axc_r     <= cfg_pwdata[AXC_W-1:0];
        REG_LEVEL_BITS: lvl_r     <= cfg_pwdata[LVL_W-1:0];
        REG_MIN_X:      wmin_r[0] <= cfg_pwdata;
        REG_MAX_X:      wmax_r[0] <= cfg_pwdata;
        REG_MIN_Y:      wmin_r[1] <= cfg_pwdata;
        REG_MAX_Y:      wmax_r[1] <= cfg_pwdata;
        REG_MIN_Z:      wmin_r[2] <= cfg_pwdata;
        REG_MAX_Z:      wmax_r[2] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_AXIS_COUNT: cfg_prdata = 32'(axc_r);
      REG_LEVEL_BITS: cfg_prdata = 32'(lvl_r);
      REG_MIN_X:      cfg_prdata = wmin_r[0];
      REG_MAX_X:      cfg_prdata = wmax_r[0];
      REG_MIN_Y:      cfg_prdata = wmin_r[1];
      REG_MAX_Y:      cfg_prdata = wmax_r[1];
      REG_MIN_Z:      cfg_prdata = wmin_r[2];
      REG_MAX_Z:      cfg_prdata = wmax_r[2];
      default:        cfg_prdata = '0;
    endcase
  end

  always_comb begin
    naxes = (axc_r == '0) ? (AXC_W+1)'(1) : {1'b0, axc_r};
    if (32'(naxes) > NL) naxes = (AXC_W+1)'(NL);
    lvl = (32'(lvl_r) > MAX_LEVEL_BITS) ? LVL_W'(MAX_LEVEL_BITS) : lvl_r;
  end

  // A new word is taken only when nothing is in work and no finished word
  // waits behind the output register.
  assign in_stall = busy_r || pend_r;
  assign accept   = in_valid && !in_stall;
  assign lanes_go = accept && (in_data.kind == KIND_BOX);
  assign do_step  = accept && (in_data.kind == KIND_STEP) && in_act;
  assign lanes_done = &ldone;
  assign do_load  = lanes_done;

  logic signed [COORD_WIDTH-1:0] bmn [3];
  logic signed [COORD_WIDTH-1:0] bmx [3];
  always_comb begin
    bmn[0] = COORD_WIDTH'(in_data.box_min_x);
    bmx[0] = COORD_WIDTH'(in_data.box_max_x);
    bmn[1] = COORD_WIDTH'(in_data.box_min_y);
    bmx[1] = COORD_WIDTH'(in_data.box_max_y);
    bmn[2] = COORD_WIDTH'(in_data.box_min_z);
    bmx[2] = COORD_WIDTH'(in_data.box_max_z);
  end

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_lane
    if (g < NL) begin : g_on
      gbcw_lane #(.COORD_WIDTH(COORD_WIDTH), .MAX_LEVEL_BITS(MAX_LEVEL_BITS)) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lanes_go),
        .lvl     (lvl),
        .wmin    (COORD_WIDTH'(wmin_r[g])),
        .wmax    (COORD_WIDTH'(wmax_r[g])),
        .bmin    (bmn[g]),
        .bmax    (bmx[g]),
        .done    (ldone[g]),
        .lo_cell (lo_c[g]),
        .hi_cell (hi_c[g])
      );
    end else begin : g_off
      assign lo_c[g] = '0;
      assign hi_c[g] = '0;
    end
  end

  gbcw_walker #(.MAX_AXES(MAX_AXES), .MAX_LEVEL_BITS(MAX_LEVEL_BITS)) u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (do_load),
    .step   (do_step),
    .lo_in  (lo_c),
    .hi_in  (hi_c),
    .naxes  (naxes),
    .lvl    (lvl),
    .active (in_act),
    .res    (wres)
  );

  always_comb begin
    new_valid = do_load || (accept && in_data.kind == KIND_STEP);
    new_res   = wres;
    if (accept && in_data.kind == KIND_STEP && !in_act) begin
      new_res = '{leaf_index: '0, is_last: 1'b0, idle_step: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (lanes_go) busy_r <= 1'b1;
      else if (lanes_done) busy_r <= 1'b0;
      if (ov_r && out_stall) begin
        if (new_valid) begin
          pend_r   <= 1'b1;
          pend_d_r <= new_res;
        end
      end else begin
        if (pend_r) begin
          ov_r   <= 1'b1;
          od_r   <= pend_d_r;
          pend_r <= 1'b0;
          if (new_valid) begin
            pend_r   <= 1'b1;
            pend_d_r <= new_res;
          end
        end else begin
          ov_r <= new_valid;
          if (new_valid) od_r <= new_res;
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !accept) else $error("word accepted while box in work");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    lanes_done |-> busy_r) else $error("lane finished without a box");
  a_idle_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.idle_step) |-> (out_data.leaf_index == '0 && !out_data.is_last))
    else $error("idle word carries a cell");

endmodule
